[rtl/mbht_pkg.sv]
`timescale 1ns / 1ps

package mbht_pkg;

   // Table geometry and field widths
   localparam int BUFFER_ENTRIES = 64;
   localparam int IMAGE_ENTRIES  = 64;
   localparam int MASK_BITS      = 48;
   localparam int INDEX_BITS     = 6;
   localparam int TAG_BITS       = 32;
   localparam int LAYOUT_BITS    = 31;

   localparam int BUF_SLOT_BITS = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
   localparam int IMG_SLOT_BITS = (IMAGE_ENTRIES > 1) ? $clog2(IMAGE_ENTRIES) : 1;

   // Stream payload widths, rounded up to whole bytes
   localparam int REQ_FIELD_BITS = INDEX_BITS + 2 * MASK_BITS + TAG_BITS + LAYOUT_BITS;
   localparam int RSP_FIELD_BITS = 1 + 2 * MASK_BITS + LAYOUT_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Register port
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WRITE_MASK_ADDR = 4'h0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_READ_MASK_ADDR  = 4'h8;

   // Command codes
   localparam logic CMD_BUFFER = 1'b0;
   localparam logic CMD_IMAGE  = 1'b1;

   typedef logic [MASK_BITS-1:0]     mask_type;
   typedef logic [TAG_BITS-1:0]      tag_type;
   typedef logic [LAYOUT_BITS-1:0]   layout_type;
   typedef logic [BUF_SLOT_BITS-1:0] buf_slot_type;
   typedef logic [IMG_SLOT_BITS-1:0] img_slot_type;

   localparam mask_type WRITE_MASK_RESET = MASK_BITS'(64'h0000_0008_0041_5540);
   localparam mask_type READ_MASK_RESET  = MASK_BITS'(64'h0000_0005_0020_AABF);

   typedef struct packed {
      mask_type write_mask;
      mask_type read_mask;
   } class_cfg_type;

   typedef struct packed {
      logic                  command;
      logic [INDEX_BITS-1:0] resource_index;
      mask_type              access_bits;
      mask_type              stage_bits;
      tag_type               batch_tag;
      layout_type            new_layout;
   } req_item_type;

   typedef struct packed {
      logic       barrier_needed;
      mask_type   source_stage;
      mask_type   source_access;
      layout_type prior_layout;
   } rsp_item_type;

   typedef struct packed {
      tag_type  tag;
      mask_type wr_acc;
      mask_type wr_stg;
      mask_type rd_acc;
      mask_type rd_stg;
   } buf_entry_type;

   typedef struct packed {
      mask_type   wr_acc;
      mask_type   wr_stg;
      mask_type   rd_acc;
      mask_type   rd_stg;
      layout_type layout;
   } img_entry_type;

   typedef struct packed {
      logic         en;
      buf_slot_type buf_slot;
      img_slot_type img_slot;
   } tbl_rd_type;

   typedef struct packed {
      logic          en;
      logic          kind;
      buf_slot_type  buf_slot;
      img_slot_type  img_slot;
      buf_entry_type buf_entry;
      img_entry_type img_entry;
   } tbl_wr_type;

endpackage

[rtl/mbht_csr.sv]
`timescale 1ns / 1ps

module mbht_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mbht_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [mbht_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [mbht_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready,
   output mbht_pkg::class_cfg_type                cfg
);
   import mbht_pkg::*;

   logic     wr_strobe;
   mask_type write_mask_ff;
   mask_type read_mask_ff;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Capture class masks on the access phase of a write
   always_ff @(posedge clock) begin
      if (reset) begin
         write_mask_ff <= WRITE_MASK_RESET;
         read_mask_ff  <= READ_MASK_RESET;
      end else if (wr_strobe) begin
         if (csr_paddr == CSR_WRITE_MASK_ADDR) begin
            write_mask_ff <= MASK_BITS'(csr_pwdata);
         end
         if (csr_paddr == CSR_READ_MASK_ADDR) begin
            read_mask_ff <= MASK_BITS'(csr_pwdata);
         end
      end
   end

   // Read back decode
   always_comb begin
      unique case (csr_paddr)
         CSR_WRITE_MASK_ADDR: csr_prdata = CSR_DATA_BITS'(write_mask_ff);
         CSR_READ_MASK_ADDR:  csr_prdata = CSR_DATA_BITS'(read_mask_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.write_mask = write_mask_ff;
   assign cfg.read_mask  = read_mask_ff;

endmodule

[rtl/mbht_scope_table.sv]
`timescale 1ns / 1ps

module mbht_scope_table (
   input  logic                    clock,
   input  logic                    reset,
   input  mbht_pkg::tbl_rd_type    rd,
   output mbht_pkg::buf_entry_type rd_buf_entry,
   output mbht_pkg::img_entry_type rd_img_entry,
   input  mbht_pkg::tbl_wr_type    wr
);
   import mbht_pkg::*;

   buf_entry_type buf_mem [BUFFER_ENTRIES];
   img_entry_type img_mem [IMAGE_ENTRIES];

   logic [BUFFER_ENTRIES-1:0] buf_vld_ff;
   logic [IMAGE_ENTRIES-1:0]  img_vld_ff;

   buf_entry_type buf_q_ff;
   img_entry_type img_q_ff;
   logic          buf_q_vld_ff;
   logic          img_q_vld_ff;
   buf_slot_type  rd_buf_slot_ff;
   img_slot_type  rd_img_slot_ff;

   // Last written entry, forwarded over a read that raced the write
   logic          lw_valid_ff;
   logic          lw_kind_ff;
   buf_slot_type  lw_buf_slot_ff;
   img_slot_type  lw_img_slot_ff;
   buf_entry_type lw_buf_ff;
   img_entry_type lw_img_ff;

   logic buf_fwd;
   logic img_fwd;

   // Memory write port and registered read port
   always_ff @(posedge clock) begin
      if (wr.en && wr.kind == CMD_BUFFER) begin
         buf_mem[wr.buf_slot] <= wr.buf_entry;
      end
      if (wr.en && wr.kind == CMD_IMAGE) begin
         img_mem[wr.img_slot] <= wr.img_entry;
      end
      if (rd.en) begin
         buf_q_ff       <= buf_mem[rd.buf_slot];
         img_q_ff       <= img_mem[rd.img_slot];
         rd_buf_slot_ff <= rd.buf_slot;
         rd_img_slot_ff <= rd.img_slot;
      end
      if (wr.en) begin
         lw_kind_ff     <= wr.kind;
         lw_buf_slot_ff <= wr.buf_slot;
         lw_img_slot_ff <= wr.img_slot;
         lw_buf_ff      <= wr.buf_entry;
         lw_img_ff      <= wr.img_entry;
      end
   end

   // Written-since-reset flags; an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff   <= '0;
         img_vld_ff   <= '0;
         buf_q_vld_ff <= 1'b0;
         img_q_vld_ff <= 1'b0;
         lw_valid_ff  <= 1'b0;
      end else begin
         if (rd.en) begin
            buf_q_vld_ff <= buf_vld_ff[rd.buf_slot];
            img_q_vld_ff <= img_vld_ff[rd.img_slot];
         end
         if (wr.en) begin
            lw_valid_ff <= 1'b1;
            if (wr.kind == CMD_BUFFER) begin
               buf_vld_ff[wr.buf_slot] <= 1'b1;
            end else begin
               img_vld_ff[wr.img_slot] <= 1'b1;
            end
         end
      end
   end

   // Select forwarded, stored or cleared entry
   assign buf_fwd = lw_valid_ff && lw_kind_ff == CMD_BUFFER && lw_buf_slot_ff == rd_buf_slot_ff;
   assign img_fwd = lw_valid_ff && lw_kind_ff == CMD_IMAGE && lw_img_slot_ff == rd_img_slot_ff;

   assign rd_buf_entry = buf_fwd ? lw_buf_ff : (buf_q_vld_ff ? buf_q_ff : '0);
   assign rd_img_entry = img_fwd ? lw_img_ff : (img_q_vld_ff ? img_q_ff : '0);

`ifndef SYNTHESIS
   a_buf_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr.en && wr.kind == CMD_BUFFER |=> buf_vld_ff[$past(wr.buf_slot)])
      else $error("buffer entry not marked written");

   a_img_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr.en && wr.kind == CMD_IMAGE |=> img_vld_ff[$past(wr.img_slot)])
      else $error("image entry not marked written");

   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> lw_valid_ff)
      else $error("last-write bypass not armed");
`endif

endmodule

[rtl/mbht_hazard_logic.sv]
`timescale 1ns / 1ps

module mbht_hazard_logic (
   input  mbht_pkg::class_cfg_type cfg,
   input  mbht_pkg::req_item_type  item,
   input  mbht_pkg::buf_entry_type cur_buf,
   input  mbht_pkg::img_entry_type cur_img,
   output mbht_pkg::buf_entry_type nxt_buf,
   output mbht_pkg::img_entry_type nxt_img,
   output mbht_pkg::rsp_item_type  rsp
);
   import mbht_pkg::*;

   always_comb begin
      logic          wr_hit;
      logic          rd_hit;
      logic          need;
      logic          stop;
      logic          change;
      mask_type      acc;
      mask_type      stg;
      mask_type      ss;
      mask_type      sa;
      layout_type    prev;
      buf_entry_type bn;
      img_entry_type in_e;

      acc    = item.access_bits;
      stg    = item.stage_bits;
      wr_hit = |(acc & cfg.write_mask);
      rd_hit = |(acc & cfg.read_mask);
      bn     = cur_buf;
      in_e   = cur_img;
      need   = 1'b0;
      stop   = 1'b0;
      change = 1'b0;
      ss     = '0;
      sa     = '0;
      prev   = '0;

      if (wr_hit || rd_hit) begin
         if (item.command == CMD_BUFFER) begin
            if (cur_buf.tag != item.batch_tag) begin
               // New batch: reseed the entry, no barrier
               bn.tag    = item.batch_tag;
               bn.wr_acc = wr_hit ? (acc & cfg.write_mask) : '0;
               bn.wr_stg = wr_hit ? stg : '0;
               bn.rd_acc = rd_hit ? (acc & cfg.read_mask) : '0;
               bn.rd_stg = rd_hit ? stg : '0;
            end else begin
               need = 1'b1;
               // Write waits on last write and all reads since
               if (wr_hit) begin
                  ss        = cur_buf.wr_stg | cur_buf.rd_stg;
                  sa        = cur_buf.wr_acc | cur_buf.rd_acc;
                  bn.wr_acc = acc;
                  bn.wr_stg = stg;
                  if (ss == '0) begin
                     need = 1'b0;
                     stop = 1'b1;
                  end else begin
                     bn.rd_acc = '0;
                     bn.rd_stg = '0;
                  end
               end
               // Read waits on the write scope unless its access or its stage bits are already recorded
               if (rd_hit && !stop) begin
                  ss = bn.wr_stg;
                  sa = bn.wr_acc;
                  if (((bn.rd_acc & acc) != acc) && ((bn.rd_stg & stg) != stg)) begin
                     bn.rd_acc = bn.rd_acc | acc;
                     bn.rd_stg = bn.rd_stg | stg;
                     if (bn.wr_stg == '0) begin
                        need = 1'b0;
                     end
                  end else begin
                     need = 1'b0;
                  end
               end
            end
         end else begin
            prev   = rd_hit ? cur_img.layout : '0;
            change = item.new_layout != prev;
            ss     = cur_img.wr_stg;
            sa     = cur_img.wr_acc;
            // Write or layout change closes out the read scope
            if (wr_hit || change) begin
               ss          = ss | cur_img.rd_stg;
               sa          = sa | cur_img.rd_acc;
               in_e.wr_acc = acc;
               in_e.wr_stg = stg;
               in_e.rd_acc = '0;
               in_e.rd_stg = '0;
            end
            // Skip reads that are already fully recorded
            if (rd_hit) begin
               if (((in_e.rd_acc & acc) == acc) && ((in_e.rd_stg & stg) == stg) && !change) begin
                  stop = 1'b1;
               end else begin
                  in_e.rd_acc = in_e.rd_acc | acc;
                  in_e.rd_stg = in_e.rd_stg | stg;
               end
            end
            if (!stop && (change || sa != '0 || ss != '0)) begin
               in_e.layout = item.new_layout;
               need        = 1'b1;
            end
         end
      end

      nxt_buf            = bn;
      nxt_img            = in_e;
      rsp.barrier_needed = need;
      rsp.source_stage   = need ? ss : '0;
      rsp.source_access  = need ? sa : '0;
      rsp.prior_layout   = (need && item.command == CMD_IMAGE) ? prev : '0;
   end

endmodule

[rtl/memory_barrier_hazard_tracker_core.sv]
`timescale 1ns / 1ps

// Memory barrier hazard tracker.
// req_* stream: one access beat per transfer (buffer or image, selected by
// req_tuser). rsp_* stream: one decision beat per access, in order, telling
// whether a barrier is needed plus the source stage and access masks and,
// for images, the prior layout.
// csr_* port: two 48-bit registers, write class mask at 0x0 and read class
// mask at 0x8; write them only while no access is in flight.
// An accepted access moves from the input stage to the result register.
// Throughput: one access per cycle while rsp_tready keeps up; each beat does
// one read-modify-write of a per-entry scope record, and a last-write bypass
// lets back-to-back accesses to the same entry go through without a gap.
// The input stage holds one access and the result register holds one
// decision, so one more access is taken while a result waits; further
// stalls on rsp_tready hold req_tready low.
// Reset clears the class masks to their defaults and marks every buffer and
// image entry as unused (zero scopes, zero tag, zero layout) at once.
module memory_barrier_hazard_tracker_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // {new_layout, batch_tag, stage_bits, access_bits, resource_index}, lowest bit up:
   // resource_index[5:0], access_bits[53:6], stage_bits[101:54],
   // batch_tag[133:102], new_layout[164:134]
   input  logic [mbht_pkg::REQ_TDATA_BITS-1:0]  req_tdata,
   input  logic                                 req_tuser,   // command
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // barrier_needed[0], source_stage[48:1], source_access[96:49], prior_layout[127:97]
   output logic [mbht_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mbht_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [mbht_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [mbht_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import mbht_pkg::*;

   localparam int ACC_LO = INDEX_BITS;
   localparam int STG_LO = ACC_LO + MASK_BITS;
   localparam int TAG_LO = STG_LO + MASK_BITS;
   localparam int LAY_LO = TAG_LO + TAG_BITS;

   class_cfg_type cfg;
   req_item_type  req_item;
   req_item_type  s1_item_ff;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   rsp_item_type  rsp_item_ff;
   rsp_item_type  rsp_item_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          accept;
   logic          advance;
   tbl_rd_type    tbl_rd;
   tbl_wr_type    tbl_wr;
   buf_entry_type cur_buf;
   img_entry_type cur_img;
   buf_entry_type nxt_buf;
   img_entry_type nxt_img;

   mbht_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Unpack the access beat
   assign req_item.command        = req_tuser;
   assign req_item.resource_index = req_tdata[INDEX_BITS-1:0];
   assign req_item.access_bits    = req_tdata[ACC_LO +: MASK_BITS];
   assign req_item.stage_bits     = req_tdata[STG_LO +: MASK_BITS];
   assign req_item.batch_tag      = req_tdata[TAG_LO +: TAG_BITS];
   assign req_item.new_layout     = req_tdata[LAY_LO +: LAYOUT_BITS];

   // Handshake: stage advances when the result register is free or draining
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // Read the entry as the beat is accepted
   assign tbl_rd.en       = accept;
   assign tbl_rd.buf_slot = BUF_SLOT_BITS'(req_item.resource_index);
   assign tbl_rd.img_slot = IMG_SLOT_BITS'(req_item.resource_index);

   // Write back the updated entry as the stage advances
   assign tbl_wr.en        = advance;
   assign tbl_wr.kind      = s1_item_ff.command;
   assign tbl_wr.buf_slot  = BUF_SLOT_BITS'(s1_item_ff.resource_index);
   assign tbl_wr.img_slot  = IMG_SLOT_BITS'(s1_item_ff.resource_index);
   assign tbl_wr.buf_entry = nxt_buf;
   assign tbl_wr.img_entry = nxt_img;

   mbht_scope_table u_table (
      .clock        (clock),
      .reset        (reset),
      .rd           (tbl_rd),
      .rd_buf_entry (cur_buf),
      .rd_img_entry (cur_img),
      .wr           (tbl_wr)
   );

   mbht_hazard_logic u_logic (
      .cfg     (cfg),
      .item    (s1_item_ff),
      .cur_buf (cur_buf),
      .cur_img (cur_img),
      .nxt_buf (nxt_buf),
      .nxt_img (nxt_img),
      .rsp     (rsp_item_in)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({rsp_item_ff.prior_layout, rsp_item_ff.source_access,
                                        rsp_item_ff.source_stage, rsp_item_ff.barrier_needed});

`ifndef SYNTHESIS
   a_no_barrier_no_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.barrier_needed |->
         rsp_item_ff.source_stage == '0 && rsp_item_ff.source_access == '0 &&
         rsp_item_ff.prior_layout == '0)
      else $error("source masks set without a barrier");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("stalled access lost");

   a_buffer_no_layout: assert property (@(posedge clock) disable iff (reset)
      advance && s1_item_ff.command == CMD_BUFFER |=> rsp_item_ff.prior_layout == '0)
      else $error("buffer decision carries a layout");
`endif

endmodule
